### sv/hrp_pkg.sv
// ----------------------------------------------------------------------------
// hrp_pkg
// Shared types and constants for the HTTP request head parser.
// ----------------------------------------------------------------------------
package hrp_pkg;

	localparam int unsigned FifoDepthDefault = 2;
	localparam logic [7:0]  MinLenReset      = 8'd22;

	// One classified request byte, as it travels from front to back
	typedef struct packed {
		logic [7:0] byte_val;
		logic [7:0] lower;
		logic       is_ws;
		logic       is_nl;
		logic       is_uri_start;
		logic       last;
	} hrp_cls_t;

	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_URI  = 2'd1,
		KIND_HOST = 2'd2
	} hrp_kind_t;

	typedef enum logic [1:0] {
		KW_GET  = 2'd0,
		KW_HEAD = 2'd1,
		KW_VER  = 2'd2,
		KW_HKEY = 2'd3
	} hrp_kw_t;

	typedef enum logic [11:0] {
		PH_METHOD   = 12'b0000_0000_0001,
		PH_GET      = 12'b0000_0000_0010,
		PH_HEAD     = 12'b0000_0000_0100,
		PH_SKIP_URI = 12'b0000_0000_1000,
		PH_URI      = 12'b0000_0001_0000,
		PH_SKIP_VER = 12'b0000_0010_0000,
		PH_VERSION  = 12'b0000_0100_0000,
		PH_SKIP_HK  = 12'b0000_1000_0000,
		PH_HOSTKEY  = 12'b0001_0000_0000,
		PH_SKIP_HV  = 12'b0010_0000_0000,
		PH_HOST     = 12'b0100_0000_0000,
		PH_DONE     = 12'b1000_0000_0000
	} hrp_phase_t;

	function automatic logic [3:0] kw_len(input hrp_kw_t sel);
		logic [3:0] n;
		unique case (sel)
			KW_GET:  n = 4'd3;
			KW_HEAD: n = 4'd4;
			KW_VER:  n = 4'd8;
			KW_HKEY: n = 4'd5;
			default: n = 4'd3;
		endcase
		return n;
	endfunction

	// Lower-case keyword letters
	function automatic logic [7:0] kw_char(input hrp_kw_t sel, input logic [2:0] pos);
		logic [7:0] c;
		c = 8'h00;
		unique case (sel)
			KW_GET: begin
				case (pos)
					3'd0:    c = "g";
					3'd1:    c = "e";
					3'd2:    c = "t";
					default: c = 8'h00;
				endcase
			end
			KW_HEAD: begin
				case (pos)
					3'd0:    c = "h";
					3'd1:    c = "e";
					3'd2:    c = "a";
					3'd3:    c = "d";
					default: c = 8'h00;
				endcase
			end
			KW_VER: begin
				case (pos)
					3'd0:    c = "h";
					3'd1:    c = "t";
					3'd2:    c = "t";
					3'd3:    c = "p";
					3'd4:    c = "/";
					3'd5:    c = "1";
					3'd6:    c = ".";
					default: c = "1";
				endcase
			end
			KW_HKEY: begin
				case (pos)
					3'd0:    c = "h";
					3'd1:    c = "o";
					3'd2:    c = "s";
					3'd3:    c = "t";
					3'd4:    c = ":";
					default: c = 8'h00;
				endcase
			end
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

### sv/hrp_front.sv
// ----------------------------------------------------------------------------
// hrp_front
// Input side: takes request bytes and classifies them for the parser.
// ----------------------------------------------------------------------------
module hrp_front (
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [7:0]     byte_value,
	input  logic           last_byte,
	output logic           push_valid,
	input  logic           push_ready,
	output hrp_pkg::hrp_cls_t push_item
);
	import hrp_pkg::*;

	always_comb begin
		push_item.byte_val     = byte_value;
		push_item.lower        = (byte_value >= "A" && byte_value <= "Z") ?
		                         (byte_value + 8'd32) : byte_value;
		// space, tab, LF, VT, FF, CR
		push_item.is_ws        = (byte_value == 8'd32) ||
		                         (byte_value >= 8'd9 && byte_value <= 8'd13);
		push_item.is_nl        = (byte_value == 8'd10) || (byte_value == 8'd13);
		push_item.is_uri_start = (byte_value == "/") || (byte_value == "*");
		push_item.last         = last_byte;
	end

	assign push_valid = in_valid;
	assign in_ready   = push_ready;

endmodule

### sv/hrp_fifo.sv
// ----------------------------------------------------------------------------
// hrp_fifo
// Short queue of classified bytes between front and back.
// ----------------------------------------------------------------------------
module hrp_fifo #(
	parameter int unsigned Depth = hrp_pkg::FifoDepthDefault  // power of two, 2..32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  hrp_pkg::hrp_cls_t push_item,
	output logic              pop_valid,
	input  logic              pop_ready,
	output hrp_pkg::hrp_cls_t pop_item
);
	import hrp_pkg::*;

	localparam int unsigned PtrW = $clog2(Depth);
	localparam int unsigned CntW = $clog2(Depth + 1);

	hrp_cls_t        mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            push;
	logic            pop;

	assign push_ready = (count_q != CntW'(Depth));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### sv/hrp_back.sv
// ----------------------------------------------------------------------------
// hrp_back
// Parser state machine and output register: tags each beat and gives the
// verdict on the last byte.
// ----------------------------------------------------------------------------
module hrp_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        min_len,
	input  logic              pop_valid,
	output logic              pop_ready,
	input  hrp_pkg::hrp_cls_t pop_item,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        byte_out,
	output logic [1:0]        byte_kind,
	output logic              frame_end,
	output logic              request_ok,
	output logic              body_wanted
);
	import hrp_pkg::*;

	hrp_phase_t phase_q, phase_n;
	logic [2:0] kpos_q, kpos_n;
	logic [7:0] seen_q, seen_n;
	logic       nl_q, nl_n;
	logic       get_q, get_n;
	logic       rej_q, rej_n;

	logic       out_valid_q;
	logic [7:0] byte_q;
	hrp_kind_t  kind_q;
	logic       end_q;
	logic       ok_q;
	logic       body_q;

	hrp_kind_t  kind;
	logic       completed;
	logic       match_en;
	hrp_kw_t    kw_sel;
	logic [2:0] kw_pos;
	logic [3:0] kw_next;
	logic       len_ok;
	logic       ok;
	logic       body;
	logic       pop;

	assign pop_ready = !out_valid_q || out_ready;
	assign pop       = pop_valid && pop_ready;

	always_comb begin
		phase_n   = phase_q;
		kpos_n    = kpos_q;
		seen_n    = (seen_q == 8'hFF) ? seen_q : seen_q + 8'd1;
		nl_n      = nl_q;
		get_n     = get_q;
		rej_n     = rej_q;
		kind      = KIND_NONE;
		completed = 1'b0;
		match_en  = 1'b0;
		kw_sel    = KW_GET;
		kw_pos    = kpos_q;
		kw_next   = {1'b0, kpos_q} + 4'd1;
		len_ok    = 1'b0;
		ok        = 1'b0;
		body      = 1'b0;

		if (!rej_q) begin
			unique case (phase_q)
				PH_METHOD: begin
					kpos_n = '0;
					if (pop_item.lower == "g") begin
						phase_n = PH_GET;
						kpos_n  = 3'd1;
					end else if (pop_item.lower == "h") begin
						phase_n = PH_HEAD;
						kpos_n  = 3'd1;
					end else begin
						rej_n = 1'b1;
					end
				end
				PH_GET: begin
					match_en = 1'b1;
					kw_sel   = KW_GET;
				end
				PH_HEAD: begin
					match_en = 1'b1;
					kw_sel   = KW_HEAD;
				end
				PH_SKIP_URI: begin
					if (!pop_item.is_ws) begin
						if (pop_item.is_uri_start) begin
							phase_n = PH_URI;
							kind    = KIND_URI;
						end else begin
							rej_n = 1'b1;
						end
					end
				end
				PH_URI: begin
					if (pop_item.is_ws) begin
						phase_n = PH_SKIP_VER;
					end else begin
						kind = KIND_URI;
					end
				end
				PH_SKIP_VER: begin
					if (!pop_item.is_ws) begin
						match_en = 1'b1;
						kw_sel   = KW_VER;
						kw_pos   = '0;
						phase_n  = PH_VERSION;
					end
				end
				PH_VERSION: begin
					match_en = 1'b1;
					kw_sel   = KW_VER;
				end
				PH_SKIP_HK: begin
					if (!pop_item.is_ws) begin
						match_en = 1'b1;
						kw_sel   = KW_HKEY;
						kw_pos   = '0;
						phase_n  = PH_HOSTKEY;
					end
				end
				PH_HOSTKEY: begin
					match_en = 1'b1;
					kw_sel   = KW_HKEY;
				end
				PH_SKIP_HV: begin
					if (pop_item.is_ws) begin
						nl_n = pop_item.is_nl;
					end else if (nl_q) begin
						rej_n = 1'b1;
					end else begin
						phase_n = PH_HOST;
						kind    = KIND_HOST;
					end
				end
				PH_HOST: begin
					if (pop_item.is_ws) begin
						phase_n = PH_DONE;
					end else begin
						kind = KIND_HOST;
					end
				end
				PH_DONE: begin
				end
				default: begin
				end
			endcase

			if (match_en) begin
				kw_next = {1'b0, kw_pos} + 4'd1;
				if (({1'b0, kw_pos} >= kw_len(kw_sel)) ||
				    (pop_item.lower != kw_char(kw_sel, kw_pos))) begin
					rej_n = 1'b1;
				end else if (kw_next >= kw_len(kw_sel)) begin
					kpos_n    = '0;
					completed = 1'b1;
					unique case (kw_sel)
						KW_GET: begin
							get_n   = 1'b1;
							phase_n = PH_SKIP_URI;
						end
						KW_HEAD: phase_n = PH_SKIP_URI;
						KW_VER:  phase_n = PH_SKIP_HK;
						KW_HKEY: begin
							phase_n = PH_SKIP_HV;
							nl_n    = 1'b0;
						end
						default: phase_n = PH_SKIP_URI;
					endcase
				end else begin
					kpos_n = kw_next[2:0];
				end
			end
		end

		if (pop_item.last) begin
			len_ok = (seen_n >= min_len);
			ok     = !rej_n && !completed && len_ok &&
			         ((phase_n == PH_HOST) || (phase_n == PH_DONE) ||
			          ((phase_n == PH_SKIP_HV) && !nl_n));
			body   = get_n && len_ok;
			// back to the start for the next request
			phase_n = PH_METHOD;
			kpos_n  = '0;
			seen_n  = '0;
			nl_n    = 1'b0;
			get_n   = 1'b0;
			rej_n   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_METHOD;
			kpos_q      <= '0;
			seen_q      <= '0;
			nl_q        <= 1'b0;
			get_q       <= 1'b0;
			rej_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q <= phase_n;
				kpos_q  <= kpos_n;
				seen_q  <= seen_n;
				nl_q    <= nl_n;
				get_q   <= get_n;
				rej_q   <= rej_n;
			end
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			byte_q <= pop_item.byte_val;
			kind_q <= kind;
			end_q  <= pop_item.last;
			ok_q   <= ok;
			body_q <= body;
		end
	end

	assign out_valid   = out_valid_q;
	assign byte_out    = byte_q;
	assign byte_kind   = kind_q;
	assign frame_end   = end_q;
	assign request_ok  = ok_q;
	assign body_wanted = body_q;

	a_ok_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && ok_q |-> end_q)
		else $error("verdict set on a beat that is not the last");

	a_body_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && body_q |-> end_q)
		else $error("body flag set on a beat that is not the last");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (kind_q == KIND_NONE || kind_q == KIND_URI || kind_q == KIND_HOST))
		else $error("illegal byte kind");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		pop && pop_item.last |=> (phase_q == PH_METHOD) && !rej_q && (seen_q == 8'd0))
		else $error("parser state not cleared after last byte");

endmodule

### sv/http_request_head_parser.sv
// ----------------------------------------------------------------------------
// http_request_head_parser
// Tags request bytes as URI, host or neither and checks the request head.
// ----------------------------------------------------------------------------
// Path: an accepted byte is written into the queue on the accepting edge,
//   then popped by the parser, whose update is registered into the output
//   register that drives the output ports.
// Throughput: one byte per cycle while out_ready is held high.
// Reset: arst_n clears queue, parser state and output valid;
//   the minimum length register (min_len_q) returns to 22.
module http_request_head_parser #(
	parameter int unsigned FifoDepth = hrp_pkg::FifoDepthDefault
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] byte_value,
	input  logic       last_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] byte_out,
	output logic [1:0] byte_kind,
	output logic       frame_end,
	output logic       request_ok,
	output logic       body_wanted
);
	import hrp_pkg::*;

	logic [7:0] min_len_q;
	logic       push_valid;
	logic       push_ready;
	hrp_cls_t   push_item;
	logic       pop_valid;
	logic       pop_ready;
	hrp_cls_t   pop_item;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_len_q <= MinLenReset;
		end else if (cfg_valid && cfg_ready) begin
			min_len_q <= cfg_data;
		end
	end

	hrp_front u_front (
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.byte_value (byte_value),
		.last_byte  (last_byte),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	hrp_fifo #(
		.Depth (FifoDepth)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	hrp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.min_len     (min_len_q),
		.pop_valid   (pop_valid),
		.pop_ready   (pop_ready),
		.pop_item    (pop_item),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.byte_out    (byte_out),
		.byte_kind   (byte_kind),
		.frame_end   (frame_end),
		.request_ok  (request_ok),
		.body_wanted (body_wanted)
	);

endmodule

### verif/tb_http_request_head_parser.sv
// ----------------------------------------------------------------------------
// tb_http_request_head_parser
// Self-checking bench for the request head parser. A scoreboard class keeps
// its own copy of the parse state, works out the tag and verdict for each
// accepted byte and checks every output beat in order. Stimulus is a few
// hand-written requests, then mostly well-formed random requests with random
// case, whitespace, truncation and corruption, plus raw noise. The minimum
// length register is rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_http_request_head_parser;
	timeunit 1ns;
	timeprecision 1ps;

	import hrp_pkg::*;

	class head_scoreboard;
		typedef struct packed {
			logic [7:0] b;
			logic [1:0] kind;
			logic       fe;
			logic       ok;
			logic       body;
		} tag_beat_t;

		tag_beat_t  tag_q[$];
		logic [7:0] min_len;
		hrp_phase_t phase;
		logic [2:0] kpos;
		logic [7:0] seen;
		bit         nl_skipped;
		bit         get_seen;
		bit         rejected;
		int         errors;

		function new();
			min_len = MinLenReset;
			errors  = 0;
			clear();
		endfunction

		function void clear();
			phase      = PH_METHOD;
			kpos       = '0;
			seen       = '0;
			nl_skipped = 0;
			get_seen   = 0;
			rejected   = 0;
		endfunction

		static function bit is_space(logic [7:0] b);
			return b == 8'd32 || (b >= 8'd9 && b <= 8'd13);
		endfunction

		static function logic [7:0] to_lower(logic [7:0] b);
			return (b >= "A" && b <= "Z") ? b + 8'd32 : b;
		endfunction

		function int pending();
			return tag_q.size();
		endfunction

		// 1 complete, 0 pending, -1 mismatch; position is kept on a mismatch
		function int match_kw(string kw, logic [7:0] b);
			int p;
			p = kpos;
			if (p >= kw.len() || to_lower(b) != 8'(kw[p]))
				return -1;
			p++;
			if (p >= kw.len()) begin
				kpos = '0;
				return 1;
			end
			kpos = p[2:0];
			return 0;
		endfunction

		function void note_input(logic [7:0] b, logic last);
			hrp_kind_t kind;
			bit        kw_done;
			bit        len_ok;
			int        r;
			string     kw;
			tag_beat_t t;
			kind    = KIND_NONE;
			kw_done = 0;
			if (seen != 8'hFF)
				seen++;
			if (!rejected) begin
				// first non-space after a skip starts the next keyword on this byte
				if ((phase == PH_SKIP_VER || phase == PH_SKIP_HK) && !is_space(b)) begin
					kpos  = '0;
					phase = (phase == PH_SKIP_VER) ? PH_VERSION : PH_HOSTKEY;
				end
				case (phase)
					PH_METHOD: begin
						kpos = '0;
						if (to_lower(b) == "g") begin
							phase = PH_GET;
							kpos  = 3'd1;
						end else if (to_lower(b) == "h") begin
							phase = PH_HEAD;
							kpos  = 3'd1;
						end else
							rejected = 1;
					end
					PH_GET, PH_HEAD: begin
						if (phase == PH_GET)
							kw = "get";
						else
							kw = "head";
						r = match_kw(kw, b);
						if (r < 0)
							rejected = 1;
						else if (r > 0) begin
							if (phase == PH_GET)
								get_seen = 1;
							phase   = PH_SKIP_URI;
							kw_done = 1;
						end
					end
					PH_SKIP_URI: begin
						if (!is_space(b)) begin
							if (b == "/" || b == "*") begin
								phase = PH_URI;
								kind  = KIND_URI;
							end else
								rejected = 1;
						end
					end
					PH_URI: begin
						if (is_space(b))
							phase = PH_SKIP_VER;
						else
							kind = KIND_URI;
					end
					PH_VERSION, PH_HOSTKEY: begin
						if (phase == PH_VERSION)
							kw = "http/1.1";
						else
							kw = "host:";
						r  = match_kw(kw, b);
						if (r < 0)
							rejected = 1;
						else if (r > 0) begin
							kw_done = 1;
							if (phase == PH_VERSION)
								phase = PH_SKIP_HK;
							else begin
								phase      = PH_SKIP_HV;
								nl_skipped = 0;
							end
						end
					end
					PH_SKIP_HV: begin
						if (is_space(b))
							nl_skipped = (b == 8'd10 || b == 8'd13);
						else if (nl_skipped)
							rejected = 1;
						else begin
							phase = PH_HOST;
							kind  = KIND_HOST;
						end
					end
					PH_HOST: begin
						if (is_space(b))
							phase = PH_DONE;
						else
							kind = KIND_HOST;
					end
					default: ;
				endcase
			end
			t.b    = b;
			t.kind = kind;
			t.fe   = last;
			t.ok   = 0;
			t.body = 0;
			if (last) begin
				len_ok = seen >= min_len;
				t.ok   = !rejected && !kw_done && len_ok &&
					(phase == PH_HOST || phase == PH_DONE ||
					(phase == PH_SKIP_HV && !nl_skipped));
				t.body = get_seen && len_ok;
				clear();
			end
			tag_q.push_back(t);
		endfunction

		function void check_result(logic [7:0] b, logic [1:0] kind, logic fe, logic ok,
				logic body);
			tag_beat_t t;
			if (tag_q.size() == 0) begin
				$error("output beat with nothing expected: byte_out %0h", b);
				errors++;
				return;
			end
			t = tag_q.pop_front();
			if (b !== t.b) begin
				$error("byte_out mismatch: expected %0h, actual %0h", t.b, b);
				errors++;
			end
			if (kind !== t.kind) begin
				$error("byte_kind mismatch: expected %0d, actual %0d", t.kind, kind);
				errors++;
			end
			if (fe !== t.fe) begin
				$error("frame_end mismatch: expected %0d, actual %0d", t.fe, fe);
				errors++;
			end
			if (ok !== t.ok) begin
				$error("request_ok mismatch: expected %0d, actual %0d", t.ok, ok);
				errors++;
			end
			if (body !== t.body) begin
				$error("body_wanted mismatch: expected %0d, actual %0d", t.body, body);
				errors++;
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [7:0] cfg_data = 8'd0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] byte_value = 8'd0;
	logic       last_byte = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] byte_out;
	logic [1:0] byte_kind;
	logic       frame_end;
	logic       request_ok;
	logic       body_wanted;

	head_scoreboard sb = new();

	logic [7:0] frame_buf[$];
	bit         valid_up = 0;
	bit         gaps_on = 0;
	int         burst_left = 1;
	int         phase_bytes;

	http_request_head_parser u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.byte_value  (byte_value),
		.last_byte   (last_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.byte_out    (byte_out),
		.byte_kind   (byte_kind),
		.frame_end   (frame_end),
		.request_ok  (request_ok),
		.body_wanted (body_wanted)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("Simulation FAILED");
		$finish;
	end

	// receiver: rotating stall word, reloaded whenever the stall counter wraps to zero
	logic [15:0] stall_pat = 16'hFFFF;
	logic [5:0]  stall_cnt = '0;
	always @(posedge clk) begin
		stall_cnt <= stall_cnt + 6'd1;
		if (stall_cnt == 6'd0) begin
			if ($urandom_range(0, 3) == 0)
				stall_pat <= 16'hFFFF;
			else
				stall_pat <= 16'($urandom) | 16'h0001;
		end else
			stall_pat <= {stall_pat[0], stall_pat[15:1]};
		out_ready <= stall_pat[0];
	end

	always @(posedge clk) begin
		if (out_valid === 1'b1 && out_ready === 1'b1)
			sb.check_result(byte_out, byte_kind, frame_end, request_ok, body_wanted);
	end

	task automatic push_byte(input logic [7:0] b, input logic l);
		in_valid   <= 1'b1;
		byte_value <= b;
		last_byte  <= l;
		valid_up   = 1;
		do @(posedge clk); while (in_ready !== 1'b1);
		sb.note_input(b, l);
		phase_bytes++;
	endtask

	task automatic send_frame();
		int n;
		for (int i = 0; i < frame_buf.size(); i++) begin
			push_byte(frame_buf[i], i == frame_buf.size() - 1);
			burst_left--;
			if (burst_left <= 0) begin
				burst_left = $urandom_range(1, 16);
				if (gaps_on) begin
					n = $urandom_range(1, 4);
					in_valid <= 1'b0;
					valid_up = 0;
					repeat (n) @(posedge clk);
				end
			end
		end
	endtask

	task automatic write_min_len(input logic [7:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		sb.min_len = v;
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		if (valid_up) begin
			in_valid <= 1'b0;
			valid_up = 0;
		end
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic add_str(input string s);
		for (int i = 0; i < s.len(); i++)
			frame_buf.push_back(8'(s[i]));
	endtask

	// keyword with random letter case
	task automatic add_kw(input string s);
		logic [7:0] c;
		for (int i = 0; i < s.len(); i++) begin
			c = 8'(s[i]);
			if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1)
				c = c - 8'd32;
			frame_buf.push_back(c);
		end
	endtask

	task automatic add_ws(input int lo, input int hi);
		int n;
		logic [7:0] c;
		n = $urandom_range(lo, hi);
		repeat (n) begin
			c = ($urandom_range(0, 2) == 0) ? 8'd32 : 8'($urandom_range(9, 13));
			frame_buf.push_back(c);
		end
	endtask

	task automatic add_word(input int lo, input int hi);
		int n;
		logic [7:0] c;
		n = $urandom_range(lo, hi);
		repeat (n) begin
			do c = 8'($urandom); while (head_scoreboard::is_space(c));
			frame_buf.push_back(c);
		end
	endtask

	task automatic build_random_frame();
		int cut;
		frame_buf.delete();
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 30)) frame_buf.push_back(8'($urandom));
			return;
		end
		if ($urandom_range(0, 1) == 1)
			add_kw("get");
		else
			add_kw("head");
		add_ws(0, 2);
		frame_buf.push_back($urandom_range(0, 1) ? "/" : "*");
		add_word(0, 6);
		add_ws(1, 3);
		add_kw("http/1.1");
		add_ws(0, 3);
		add_kw("host:");
		add_ws(0, 3);
		add_word(0, 8);
		if ($urandom_range(0, 1) == 1) begin
			add_ws(1, 2);
			if ($urandom_range(0, 9) == 0)
				add_word(200, 260);
			else
				add_word(0, 8);
		end
		if ($urandom_range(0, 5) == 0)
			frame_buf[$urandom_range(0, frame_buf.size() - 1)] = 8'($urandom);
		if ($urandom_range(0, 5) == 0) begin
			cut = $urandom_range(1, frame_buf.size());
			while (frame_buf.size() > cut)
				void'(frame_buf.pop_back());
		end
	endtask

	initial begin
		string      directed[$];
		logic [7:0] cfg_vals[6];

		directed = '{
			"GET / HTTP/1.1\nHost:\n",
			"get /a http/1.1 host: x",
			"HeAd *\tHTTP/1.1\015\nHOST:\013\014ex.org\015\n tail",
			"G",
			"GET",
			"GET / HTTP/1.1 Host:\nabc",
			"GET / HTTP/1.1 Host:   \015",
			"GET / HTTP/1.1 Host:    ",
			"HEAD x",
			"POST / HTTP/1.1 Host: a",
			"GET\t/ HTTP/1.0 Host: a"
		};
		cfg_vals[0] = 8'd0;
		cfg_vals[1] = 8'd255;
		cfg_vals[2] = 8'($urandom);
		cfg_vals[3] = 8'd1;
		cfg_vals[4] = 8'($urandom_range(10, 40));
		cfg_vals[5] = 8'd22;

		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed set runs on the reset value of the length register
		phase_bytes = 0;
		foreach (directed[i]) begin
			frame_buf.delete();
			add_str(directed[i]);
			send_frame();
		end
		frame_buf = '{8'h00};
		send_frame();
		frame_buf = '{8'hFF};
		send_frame();
		drain();

		foreach (cfg_vals[p]) begin
			write_min_len(cfg_vals[p]);
			gaps_on     = ($urandom_range(0, 3) != 0);
			phase_bytes = 0;
			while (phase_bytes < 150) begin
				build_random_frame();
				send_frame();
			end
			drain();
		end

		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
